>>> rtl/pwl_pkg.sv
package pwl_pkg;

  localparam int unsigned TableDepthDefault = 64;
  localparam int unsigned CmdQueueDepth = 2;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_BELOW = 3'd1,
    ST_ABOVE = 3'd2,
    ST_FULL  = 3'd3,
    ST_EMPTY = 3'd4,
    ST_ORDER = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic signed [31:0] query_x;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] y_value;
    logic [6:0]         entry_count;
  } out_beat_t;

endpackage

>>> rtl/piecewise_linear_table_interp_unit.sv
// Channel  | Direction | Handshake                | Payload
// command  | in        | start & !busy            | cmd_i   (pwl_pkg::in_beat_t)
// result   | out       | done_o, one cycle        | res_o   (pwl_pkg::out_beat_t)
//
// Engine steps per beat: clear, no-op and full/empty refusals go straight to the
// result; append reads the last entry and checks the order; a query scans the
// breakpoints in order and, to interpolate, runs a 64-step serial divide.
// rst_ni is asynchronous, active low; it empties the table (entry count 0).
// A two-beat queue sits ahead of the engine; busy is high while it is full.
// The receiver cannot stall: each result beat shows for exactly one cycle.
module piecewise_linear_table_interp_unit #(
  parameter int unsigned TableDepth = pwl_pkg::TableDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  pwl_pkg::in_beat_t  cmd_i,
  output logic               done_o,
  output pwl_pkg::out_beat_t res_o
);
  logic              q_full, q_empty, q_pop;
  pwl_pkg::in_beat_t q_data;

  assign busy = q_full;

  pwl_cmd_queue #(
    .Depth(pwl_pkg::CmdQueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (start && !q_full),
    .push_data_i(cmd_i),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_data_o (q_data)
  );

  pwl_engine #(
    .TableDepth(TableDepth)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!q_empty),
    .cmd_i      (q_data),
    .cmd_pop_o  (q_pop),
    .res_valid_o(done_o),
    .res_o      (res_o)
  );
endmodule

>>> rtl/pwl_cmd_queue.sv
// Small FIFO between the command front end and the table engine.
module pwl_cmd_queue #(
  parameter int unsigned Depth = pwl_pkg::CmdQueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pwl_pkg::in_beat_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output pwl_pkg::in_beat_t pop_data_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  pwl_pkg::in_beat_t mem_q [Depth];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end
endmodule

>>> rtl/pwl_divider.sv
// Restoring divider: 64-bit unsigned dividend by 32-bit divisor, one bit a cycle.
module pwl_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);
  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q;
  logic [6:0]  cnt_q, cnt_d;
  logic        run_q, run_d, done_q, done_d;
  logic [33:0] trial;
  logic [32:0] shifted;

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    done_d  = 1'b0;
    shifted = {rem_q[31:0], quo_q[63]};
    trial   = {1'b0, shifted} - {2'b00, dvs_q};
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = 7'd64;
      run_d = 1'b1;
    end else if (run_q) begin
      if (!trial[33]) begin
        rem_d = trial[32:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 7'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end
endmodule

>>> rtl/pwl_engine.sv
// Table engine: holds breakpoints, runs append checks and the query search.
module pwl_engine #(
  parameter int unsigned TableDepth = pwl_pkg::TableDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  pwl_pkg::in_beat_t  cmd_i,
  output logic               cmd_pop_o,
  output logic               res_valid_o,
  output pwl_pkg::out_beat_t res_o
);
  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned NW = $clog2(TableDepth + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LAST  = 8'b0000_0010,
    S_APPND = 8'b0000_0100,
    S_SRCH  = 8'b0000_1000,
    S_PREV  = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] mem_x [TableDepth];
  logic [31:0] mem_y [TableDepth];
  logic [31:0] rd_x, rd_y;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  logic [NW-1:0] count_q, count_d;
  logic [NW-1:0] idx_q, idx_d;
  pwl_pkg::in_beat_t cmd_q;
  logic signed [31:0] x1_q, y1_q, x1_d, y1_d;
  logic [63:0] prod_q;
  logic [31:0] dvs_q;
  logic        neg_q;
  logic [2:0]  st_q, st_d;
  logic signed [31:0] yo_q, yo_d;
  logic        valid_q, valid_d;
  logic        div_start, div_done;
  logic [63:0] div_quo;
  logic signed [32:0] dy;
  logic [31:0] dx, dt;
  logic [31:0] mag;
  logic signed [31:0] q;

  assign q         = cmd_q.query_x;
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;
  assign res_valid_o       = valid_q;
  assign res_o.status      = st_q;
  assign res_o.y_value     = yo_q;
  assign res_o.entry_count = 7'(count_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[count_q[AW-1:0]] <= cmd_q.load_x;
      mem_y[count_q[AW-1:0]] <= cmd_q.load_y;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

  pwl_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(prod_q),
    .divisor_i (dvs_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // x0 < q < x1, so both spans are positive and fit 32 unsigned bits
  always_comb begin
    dy  = {rd_y[31], rd_y} - {y1_q[31], y1_q};
    dx  = x1_q - rd_x;
    dt  = x1_q - q;
    mag = dy[32] ? 32'(-dy) : dy[31:0];
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    x1_d      = x1_q;
    y1_d      = y1_q;
    st_d      = st_q;
    yo_d      = yo_q;
    valid_d   = 1'b0;
    wr_en     = 1'b0;
    div_start = 1'b0;
    rd_addr   = idx_q[AW-1:0];
    case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (cmd_valid_i) begin
          st_d = pwl_pkg::ST_OK;
          yo_d = '0;
          case (pwl_pkg::cmd_e'(cmd_i.command))
            pwl_pkg::CMD_CLEAR: begin
              count_d = '0;
              state_d = S_DONE;
            end
            pwl_pkg::CMD_APPEND: begin
              if (count_q == NW'(TableDepth)) begin
                st_d    = pwl_pkg::ST_FULL;
                state_d = S_DONE;
              end else begin
                state_d = S_LAST;
              end
            end
            pwl_pkg::CMD_QUERY: begin
              if (count_q == '0) begin
                st_d    = pwl_pkg::ST_EMPTY;
                state_d = S_DONE;
              end else begin
                state_d = S_SRCH;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
        // first read for append (last entry) or search (entry 0)
        if (cmd_valid_i && cmd_i.command == pwl_pkg::CMD_APPEND) begin
          rd_addr = AW'(count_q - 1'b1);
        end else begin
          rd_addr = '0;
        end
      end
      S_LAST: begin
        rd_addr = AW'(count_q - 1'b1);
        state_d = S_APPND;
      end
      S_APPND: begin
        if (count_q != '0 && $signed(cmd_q.load_x) <= $signed(rd_x)) begin
          st_d = pwl_pkg::ST_ORDER;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
        end
        state_d = S_DONE;
      end
      S_SRCH: begin
        // rd_x holds entry idx_q; one entry per cycle
        if (q > $signed(rd_x)) begin
          if (idx_q + 1'b1 == count_q) begin
            st_d    = pwl_pkg::ST_ABOVE;
            state_d = S_DONE;
          end else begin
            idx_d   = idx_q + 1'b1;
            rd_addr = AW'(idx_q + 1'b1);
          end
        end else if (q == $signed(rd_x)) begin
          yo_d    = rd_y;
          state_d = S_DONE;
        end else if (idx_q == '0) begin
          st_d    = pwl_pkg::ST_BELOW;
          state_d = S_DONE;
        end else begin
          x1_d    = rd_x;
          y1_d    = rd_y;
          rd_addr = AW'(idx_q - 1'b1);
          state_d = S_PREV;
        end
      end
      S_PREV: state_d = S_MUL;
      S_MUL: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          yo_d    = neg_q ? y1_q - div_quo[31:0] : y1_q + div_quo[31:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_valid_i) begin
      cmd_q <= cmd_i;
    end
    idx_q <= idx_d;
    x1_q  <= x1_d;
    y1_q  <= y1_d;
    st_q  <= st_d;
    yo_q  <= yo_d;
    // rd_x/rd_y hold x0, y0 here
    if (state_q == S_PREV) begin
      prod_q <= 64'(mag) * 64'(dt);
      dvs_q  <= dx;
      neg_q  <= dy[32];
    end
  end
endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

// Self-checking bench for the piecewise linear interpolation unit.
// A directed table covers the corner cases (empty table, below/above range,
// exact breakpoint hits, repeated x, unused command, clear), a fill checks
// the full table, then random traffic builds tables of varying size and
// queries them. Every accepted beat is run through a local table model;
// result beats are checked in order against the queue of predicted beats.
module tb_top;

  localparam int unsigned Depth = pwl_pkg::TableDepthDefault;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles = 400;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  pwl_pkg::in_beat_t  cmd_i = '0;
  logic               done_o;
  pwl_pkg::out_beat_t res_o;

  piecewise_linear_table_interp_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .cmd_i (cmd_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // local copy of the breakpoint table
  logic signed [31:0] bp_x[Depth];
  logic signed [31:0] bp_y[Depth];
  int unsigned        bp_count;

  pwl_pkg::out_beat_t pending_results[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned idle_pct;

  // Interpolate between (x0,y0) and (x1,y1) with a 64-bit magnitude product,
  // truncating the quotient toward zero before applying the sign.
  function automatic logic signed [31:0] interp_y(
    input logic signed [31:0] x0, input logic signed [31:0] y0,
    input logic signed [31:0] x1, input logic signed [31:0] y1,
    input logic signed [31:0] q);
    logic signed [63:0] dy;
    logic [63:0]        span_t;
    logic [63:0]        span_d;
    logic [63:0]        mag;
    logic [63:0]        quo;
    logic signed [63:0] y;
    dy = 64'(y0) - 64'(y1);
    span_t = 64'(64'(x1) - 64'(q));
    span_d = 64'(64'(x1) - 64'(x0));
    mag = dy[63] ? 64'(-dy) : 64'(dy);
    quo = (mag * span_t) / span_d;
    y = dy[63] ? 64'(y1) - $signed(quo) : 64'(y1) + $signed(quo);
    return y[31:0];
  endfunction

  // Apply one command beat to the local table and return the expected beat.
  function automatic pwl_pkg::out_beat_t table_step(input pwl_pkg::in_beat_t b);
    pwl_pkg::out_beat_t r;
    int unsigned i;
    r = '0;
    r.status = pwl_pkg::ST_OK;
    case (pwl_pkg::cmd_e'(b.command))
      pwl_pkg::CMD_CLEAR: begin
        bp_count = 0;
      end
      pwl_pkg::CMD_APPEND: begin
        if (bp_count >= Depth) begin
          r.status = pwl_pkg::ST_FULL;
        end else if (bp_count > 0 && b.load_x <= bp_x[bp_count-1]) begin
          r.status = pwl_pkg::ST_ORDER;
        end else begin
          bp_x[bp_count] = b.load_x;
          bp_y[bp_count] = b.load_y;
          bp_count++;
        end
      end
      pwl_pkg::CMD_QUERY: begin
        if (bp_count == 0) begin
          r.status = pwl_pkg::ST_EMPTY;
        end else begin
          i = 0;
          while (i < bp_count && b.query_x > bp_x[i]) i++;
          if (i >= bp_count) r.status = pwl_pkg::ST_ABOVE;
          else if (b.query_x == bp_x[i]) r.y_value = bp_y[i];
          else if (i == 0) r.status = pwl_pkg::ST_BELOW;
          else r.y_value = interp_y(bp_x[i-1], bp_y[i-1], bp_x[i], bp_y[i], b.query_x);
        end
      end
      default: ;
    endcase
    r.entry_count = 7'(bp_count);
    return r;
  endfunction

  // Present one beat, holding start until accepted; the model is stepped
  // on acceptance. start stays high after acceptance so a following beat can
  // go out on the next edge; idling and wait_drained take it low.
  task automatic send_beat(input pwl_pkg::in_beat_t b, input bit has_fixed,
                           input pwl_pkg::out_beat_t fixed);
    pwl_pkg::out_beat_t exp_r;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    exp_r = table_step(b);
    if (has_fixed && exp_r != fixed) begin
      $error("directed row disagrees with table model: %h vs %h", fixed, exp_r);
      error_count++;
    end
    pending_results.push_back(exp_r);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    pwl_pkg::out_beat_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", res_o);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (res_o.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, res_o.status);
          error_count++;
        end
        if (res_o.y_value !== exp_r.y_value) begin
          $error("y_value: expected %h, got %h", exp_r.y_value, res_o.y_value);
          error_count++;
        end
        if (res_o.entry_count !== exp_r.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.entry_count,
                 res_o.entry_count);
          error_count++;
        end
      end
    end
  end

  // watchdog: cycles with neither an input nor a result beat
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic pwl_pkg::in_beat_t mk(input pwl_pkg::cmd_e c, input logic [31:0] lx,
                                           input logic [31:0] ly, input logic [31:0] q);
    pwl_pkg::in_beat_t b;
    b.command = c;
    b.load_x = lx;
    b.load_y = ly;
    b.query_x = q;
    return b;
  endfunction

  function automatic pwl_pkg::out_beat_t mr(input pwl_pkg::status_e s,
                                            input logic [31:0] y, input int unsigned n);
    pwl_pkg::out_beat_t r;
    r.status = s;
    r.y_value = y;
    r.entry_count = 7'(n);
    return r;
  endfunction

  function automatic logic [31:0] rnd32();
    return $urandom();
  endfunction

  // directed table: beat, whether an expectation is typed in, the expectation
  typedef struct {
    pwl_pkg::in_beat_t  b;
    bit                 fixed;
    pwl_pkg::out_beat_t r;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic random_table_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned npts;
    int unsigned k;
    logic signed [31:0] x;
    logic signed [31:0] step;
    pwl_pkg::in_beat_t b;
    sent = 0;
    while (sent < n_items) begin
      // mostly: clear, build an ascending table, query it; sometimes noise
      send_beat(mk(pwl_pkg::CMD_CLEAR, rnd32(), rnd32(), rnd32()), 0, '0);
      sent++;
      npts = ($urandom_range(9) == 0) ? $urandom_range(Depth + 2, 40)
                                      : $urandom_range(8, 1);
      x = $urandom_range(3) == 0 ? 32'sh8000_0000 + $urandom_range(1000)
                                 : $signed(rnd32()) >>> 4;
      for (k = 0; k < npts; k++) begin
        b = mk(pwl_pkg::CMD_APPEND, x, rnd32(), rnd32());
        // occasionally a non-ascending x
        if ($urandom_range(15) == 0 && bp_count > 0) b.load_x = bp_x[bp_count-1] - $urandom_range(2);
        send_beat(b, 0, '0);
        sent++;
        step = $urandom_range(1) ? $urandom_range(32'h00ff_ffff, 1)
                                 : $urandom_range(32'h3fff_ffff, 1);
        if (x > 32'sh7fff_ffff - step) x = 32'sh7fff_ffff;
        else x = x + step;
      end
      for (k = 0; k < $urandom_range(12, 2); k++) begin
        b = mk(pwl_pkg::CMD_QUERY, rnd32(), rnd32(), rnd32());
        case ($urandom_range(5))
          0, 1, 2: if (bp_count > 1) begin
            int unsigned j;
            logic [31:0] span;
            j = $urandom_range(bp_count - 1, 1);
            span = bp_x[j] - bp_x[j-1];
            b.query_x = bp_x[j-1] + $signed($urandom() % span);
          end
          3: if (bp_count > 0) b.query_x = bp_x[$urandom_range(bp_count - 1)];
          4: b.command = $urandom_range(1) ? pwl_pkg::CMD_NONE : pwl_pkg::CMD_QUERY;
          default: ;
        endcase
        send_beat(b, 0, '0);
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned k;
    error_count = 0;
    bp_count = 0;
    idle_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, unused command, extremes of the fields
    dir_rows.push_back('{mk(pwl_pkg::CMD_QUERY, 0, 0, 0), 1, mr(pwl_pkg::ST_EMPTY, 0, 0)});
    dir_rows.push_back('{mk(pwl_pkg::CMD_NONE, '1, '1, '1), 1, mr(pwl_pkg::ST_OK, 0, 0)});
    dir_rows.push_back('{mk(pwl_pkg::CMD_APPEND, 32'h8000_0000, 32'h7fff_ffff, '1), 1,
                         mr(pwl_pkg::ST_OK, 0, 1)});
    dir_rows.push_back('{mk(pwl_pkg::CMD_APPEND, 32'h8000_0000, 0, 0), 1,
                         mr(pwl_pkg::ST_ORDER, 0, 1)});
    dir_rows.push_back('{mk(pwl_pkg::CMD_APPEND, 32'h7fff_ffff, 32'h8000_0000, 0), 1,
                         mr(pwl_pkg::ST_OK, 0, 2)});
    dir_rows.push_back('{mk(pwl_pkg::CMD_QUERY, 0, 0, 32'h8000_0000), 1,
                         mr(pwl_pkg::ST_OK, 32'h7fff_ffff, 2)});
    dir_rows.push_back('{mk(pwl_pkg::CMD_QUERY, 0, 0, 32'h7fff_ffff), 1,
                         mr(pwl_pkg::ST_OK, 32'h8000_0000, 2)});
    dir_rows.push_back('{mk(pwl_pkg::CMD_QUERY, 0, 0, 0), 0, '0});
    dir_rows.push_back('{mk(pwl_pkg::CMD_QUERY, 0, 0, 32'h7fff_fffe), 0, '0});
    dir_rows.push_back('{mk(pwl_pkg::CMD_QUERY, 0, 0, 32'h8000_0001), 0, '0});
    dir_rows.push_back('{mk(pwl_pkg::CMD_CLEAR, '1, '1, '1), 1, mr(pwl_pkg::ST_OK, 0, 0)});
    dir_rows.push_back('{mk(pwl_pkg::CMD_APPEND, 32'h0001_0000, 32'h0005_0000, 0), 1,
                         mr(pwl_pkg::ST_OK, 0, 1)});
    dir_rows.push_back('{mk(pwl_pkg::CMD_APPEND, 32'h0001_0000, 0, 0), 1,
                         mr(pwl_pkg::ST_ORDER, 0, 1)});
    dir_rows.push_back('{mk(pwl_pkg::CMD_APPEND, 32'h0003_0000, 32'hfffb_0000, 0), 1,
                         mr(pwl_pkg::ST_OK, 0, 2)});
    dir_rows.push_back('{mk(pwl_pkg::CMD_QUERY, 0, 0, 32'h0000_ffff), 1,
                         mr(pwl_pkg::ST_BELOW, 0, 2)});
    dir_rows.push_back('{mk(pwl_pkg::CMD_QUERY, 0, 0, 32'h0003_0001), 1,
                         mr(pwl_pkg::ST_ABOVE, 0, 2)});
    dir_rows.push_back('{mk(pwl_pkg::CMD_QUERY, 0, 0, 32'h0002_0000), 1,
                         mr(pwl_pkg::ST_OK, 0, 2)});
    dir_rows.push_back('{mk(pwl_pkg::CMD_QUERY, 0, 0, 32'h0001_8001), 0, '0});
    dir_rows.push_back('{mk(pwl_pkg::CMD_QUERY, 0, 0, 32'h0002_7fff), 0, '0});
    dir_rows.push_back('{mk(pwl_pkg::CMD_CLEAR, 0, 0, 0), 1, mr(pwl_pkg::ST_OK, 0, 0)});
    foreach (dir_rows[i]) send_beat(dir_rows[i].b, dir_rows[i].fixed, dir_rows[i].r);

    // fill to the limit, then one more append must report full
    for (k = 0; k < Depth; k++) begin
      send_beat(mk(pwl_pkg::CMD_APPEND, k * 32'h0010_0000, rnd32(), 0), 0, '0);
    end
    send_beat(mk(pwl_pkg::CMD_APPEND, 32'h7fff_ffff, 0, 0), 1,
              mr(pwl_pkg::ST_FULL, 0, Depth));
    send_beat(mk(pwl_pkg::CMD_QUERY, 0, 0, 32'h03f0_0000), 0, '0);
    send_beat(mk(pwl_pkg::CMD_QUERY, 0, 0, 32'h03e8_1234), 0, '0);

    // sender holds off until every result is back
    wait_drained();

    // random traffic across idling phases
    idle_pct = 0;
    random_table_phase(330);
    idle_pct = 47;
    random_table_phase(330);
    wait_drained();
    idle_pct = 17;
    random_table_phase(320);
    idle_pct = 0;
    random_table_phase(320);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

>>> files.f
rtl/pwl_pkg.sv
rtl/pwl_cmd_queue.sv
rtl/pwl_divider.sv
rtl/pwl_engine.sv
rtl/piecewise_linear_table_interp_unit.sv
test/tb_top.sv
